FILE: hdl/depth_laplacian_edge_filter_defines.svh
// ----------------------------------------------------------------------------
// depth_laplacian_edge_filter_defines.svh
// Assertion macros shared by the edge filter RTL.
// ----------------------------------------------------------------------------
`ifndef DEPTH_LAPLACIAN_EDGE_FILTER_DEFINES_SVH
`define DEPTH_LAPLACIAN_EDGE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DLEF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlef assertion failed");

// Next-cycle implication, disabled in reset.
`define DLEF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlef assertion failed");

`endif

FILE: hdl/dlef_pkg.sv
// ----------------------------------------------------------------------------
// dlef_pkg
// Widths, register indexes and shared types of the depth edge filter.
// ----------------------------------------------------------------------------
package dlef_pkg;

  localparam int DEPTH_BITS = 16;
  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);      // column index
  localparam int WID_W      = $clog2(MAX_WIDTH) + 1;  // holds MAX_WIDTH itself
  localparam int ROW_W      = 16;
  localparam int VAL_W      = DEPTH_BITS + 2;         // edge value / threshold
  localparam int SUM_W      = DEPTH_BITS + 2;         // sum of four neighbours
  localparam int RESP_W     = DEPTH_BITS + 3;         // signed response

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int THR_W      = 18;
  localparam int IMGW_W     = 12;
  localparam int IMGH_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd2;

  localparam logic [THR_W-1:0]  THR_RESET    = 18'd328;   // 0.005 in Q0.16
  localparam logic [IMGW_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [IMGH_W-1:0] HEIGHT_RESET = 16'd480;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef logic [DEPTH_BITS-1:0] depth_t;

  // One kernel job from front to back.
  typedef struct packed {
    depth_t            up;
    depth_t            centre;
    depth_t            left;
    depth_t            right;
    depth_t            down;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              last;
  } dlef_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dlef_qstat_t;

endpackage

FILE: hdl/dlef_in_if.sv
// ----------------------------------------------------------------------------
// dlef_in_if
// Depth sample channel: valid/ready with sample and flush mark.
// ----------------------------------------------------------------------------
interface dlef_in_if;
  logic                         valid;
  logic                         ready;
  logic [dlef_pkg::DEPTH_BITS-1:0] depth_sample;
  logic                         flush;

  modport source (output valid, output depth_sample, output flush, input ready);
  modport sink   (input valid, input depth_sample, input flush, output ready);
endinterface

FILE: hdl/dlef_out_if.sv
// ----------------------------------------------------------------------------
// dlef_out_if
// Edge result channel: valid/ready with value, coordinates and frame end.
// ----------------------------------------------------------------------------
interface dlef_out_if;
  logic                        valid;
  logic                        ready;
  logic [dlef_pkg::VAL_W-1:0]  edge_value;
  logic [dlef_pkg::COL_W-1:0]  pixel_x;
  logic [dlef_pkg::ROW_W-1:0]  pixel_y;
  logic                        last_of_frame;

  modport source (output valid, output edge_value, output pixel_x, output pixel_y,
                  output last_of_frame, input ready);
  modport sink   (input valid, input edge_value, input pixel_x, input pixel_y,
                  input last_of_frame, output ready);
endinterface

FILE: hdl/dlef_front.sv
// ----------------------------------------------------------------------------
// dlef_front
// Raster tracking, line stores with prefetch, and job issue to the queue.
// ----------------------------------------------------------------------------
module dlef_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          refresh_req,
  input  logic [dlef_pkg::WID_W-1:0]    w_eff,
  input  logic [dlef_pkg::ROW_W-1:0]    h_eff,
  dlef_in_if.sink                       in_ch,
  input  dlef_pkg::dlef_qstat_t         q_stat,
  output logic                          push,
  output dlef_pkg::dlef_cmd_t           cmd
);

  dlef_pkg::depth_t upper_mem [dlef_pkg::MAX_WIDTH];
  dlef_pkg::depth_t mid_mem   [dlef_pkg::MAX_WIDTH];

  logic [dlef_pkg::COL_W-1:0] col_r;
  logic [dlef_pkg::ROW_W-1:0] row_r;
  logic                       pf_valid_r;
  dlef_pkg::depth_t           win_c_r;

  dlef_pkg::depth_t rd_up_r, rd_mid_r, rd_rt_r;
  dlef_pkg::depth_t fwd_up_d_r, fwd_dn_d_r;
  logic             fwd_up_r, fwd_mid_r, fwd_rt_r;
  logic             fwd_up_nxt, fwd_mid_nxt, fwd_rt_nxt;

  dlef_pkg::depth_t cur_up, cur_mid, cur_rt;
  dlef_pkg::depth_t up, left, right, down;

  logic [dlef_pkg::WID_W-1:0] col_p1;
  logic                       draining, acc, adv, emit, wr, rd_en;
  logic [dlef_pkg::COL_W-1:0] ncol, norm_col, rd_a0, rd_a1;
  logic [dlef_pkg::ROW_W-1:0] nrow, norm_row;

  // read data with write-first bypass for narrow images
  assign cur_up  = fwd_up_r  ? fwd_up_d_r : rd_up_r;
  assign cur_mid = fwd_mid_r ? fwd_dn_d_r : rd_mid_r;
  assign cur_rt  = fwd_rt_r  ? fwd_dn_d_r : rd_rt_r;

  assign col_p1   = {1'b0, col_r} + dlef_pkg::WID_W'(1);
  assign draining = (row_r == h_eff);
  assign acc      = in_ch.valid && in_ch.ready;
  assign adv      = acc && !(in_ch.flush && !draining);  // flush in image: dropped
  assign emit     = (row_r != '0);
  assign wr       = adv && !draining;

  assign up    = (row_r >= dlef_pkg::ROW_W'(2)) ? cur_up : '0;
  assign left  = (col_r != '0) ? win_c_r : '0;
  assign right = (col_p1 < w_eff) ? cur_rt : '0;
  assign down  = draining ? '0 : in_ch.depth_sample;

  always_comb begin
    if (col_p1 >= w_eff) begin
      ncol = '0;
      nrow = draining ? '0 : row_r + dlef_pkg::ROW_W'(1);
    end else begin
      ncol = col_p1[dlef_pkg::COL_W-1:0];
      nrow = row_r;
    end
  end

  // position repair after a register change
  always_comb begin
    norm_col = col_r;
    norm_row = row_r;
    if ({1'b0, col_r} >= w_eff) begin
      norm_col = '0;
      norm_row = row_r + dlef_pkg::ROW_W'(1);
    end
    if (norm_row > h_eff) begin
      norm_row = '0;
    end
  end

  assign rd_en = adv || !pf_valid_r;
  assign rd_a0 = pf_valid_r ? ncol : norm_col;
  assign rd_a1 = rd_a0 + dlef_pkg::COL_W'(1);

  assign fwd_up_nxt  = wr && (rd_a0 == col_r);
  assign fwd_mid_nxt = wr && (rd_a0 == col_r);
  assign fwd_rt_nxt  = wr && (rd_a1 == col_r);

  assign in_ch.ready = pf_valid_r && !q_stat.full;
  assign push        = adv && emit;

  assign cmd.up     = up;
  assign cmd.centre = cur_mid;
  assign cmd.left   = left;
  assign cmd.right  = right;
  assign cmd.down   = down;
  assign cmd.col    = col_r;
  assign cmd.row    = row_r - dlef_pkg::ROW_W'(1);
  assign cmd.last   = (col_p1 == w_eff) && draining;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      pf_valid_r <= 1'b0;
      win_c_r    <= '0;
      fwd_up_r   <= 1'b0;
      fwd_mid_r  <= 1'b0;
      fwd_rt_r   <= 1'b0;
    end else begin
      if (refresh_req) begin
        pf_valid_r <= 1'b0;
      end else if (!pf_valid_r) begin
        pf_valid_r <= 1'b1;
        col_r      <= norm_col;
        row_r      <= norm_row;
      end
      if (adv) begin
        col_r <= ncol;
        row_r <= nrow;
        if (emit) begin
          win_c_r <= cur_mid;
        end
      end
      if (rd_en) begin
        fwd_up_r  <= fwd_up_nxt;
        fwd_mid_r <= fwd_mid_nxt;
        fwd_rt_r  <= fwd_rt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_up_r    <= upper_mem[rd_a0];
      rd_mid_r   <= mid_mem[rd_a0];
      rd_rt_r    <= mid_mem[rd_a1];
      fwd_up_d_r <= cur_mid;
      fwd_dn_d_r <= down;
    end
    if (wr) begin
      upper_mem[col_r] <= cur_mid;
      mid_mem[col_r]   <= down;
    end
  end

endmodule

FILE: hdl/dlef_queue.sv
// ----------------------------------------------------------------------------
// dlef_queue
// Small job FIFO between front and back.
// ----------------------------------------------------------------------------
module dlef_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dlef_pkg::dlef_cmd_t   push_cmd,
  input  logic                  pop,
  output dlef_pkg::dlef_cmd_t   head,
  output dlef_pkg::dlef_qstat_t q_stat
);

  dlef_pkg::dlef_cmd_t        slot_r [dlef_pkg::Q_DEPTH];
  logic [dlef_pkg::Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [dlef_pkg::Q_CW-1:0]  count_r;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == dlef_pkg::Q_CW'(dlef_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + dlef_pkg::Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + dlef_pkg::Q_AW'(1);
      if (push && !pop) begin
        count_r <= count_r + dlef_pkg::Q_CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - dlef_pkg::Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

FILE: hdl/dlef_back.sv
// ----------------------------------------------------------------------------
// dlef_back
// Laplacian response, threshold and output register.
// ----------------------------------------------------------------------------
module dlef_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [dlef_pkg::THR_W-1:0]  thr,
  input  dlef_pkg::dlef_cmd_t         head,
  input  dlef_pkg::dlef_qstat_t       q_stat,
  output logic                        pop,
  dlef_out_if.source                  out_ch
);

  logic                               out_valid_r;
  logic [dlef_pkg::VAL_W-1:0]         edge_r;
  logic [dlef_pkg::COL_W-1:0]         px_r;
  logic [dlef_pkg::ROW_W-1:0]         py_r;
  logic                               last_r;

  logic [dlef_pkg::SUM_W-1:0]         nsum;
  logic signed [dlef_pkg::RESP_W-1:0] resp;
  logic [dlef_pkg::VAL_W-1:0]         edge_nxt;

  assign pop = !q_stat.empty && (!out_valid_r || out_ch.ready);

  // 4*centre - (up + down + left + right)
  assign nsum = dlef_pkg::SUM_W'(head.up) + dlef_pkg::SUM_W'(head.down)
              + dlef_pkg::SUM_W'(head.left) + dlef_pkg::SUM_W'(head.right);
  assign resp = $signed({1'b0, head.centre, 2'b00}) - $signed({1'b0, nsum});
  assign edge_nxt = (resp > $signed({1'b0, thr})) ? resp[dlef_pkg::VAL_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      edge_r <= edge_nxt;
      px_r   <= head.col;
      py_r   <= head.row;
      last_r <= head.last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.edge_value    = edge_r;
  assign out_ch.pixel_x       = px_r;
  assign out_ch.pixel_y       = py_r;
  assign out_ch.last_of_frame = last_r;

endmodule

FILE: hdl/depth_laplacian_edge_filter.sv
// Result path: the result for pixel (x, y) is issued by the transfer of item (x, y+1)
//   and then passes through the queue slot and the output register.
// Throughput: 1 item per cycle, set by the single-port-write line stores and
//   a one-item-per-cycle back end; a full 4-entry queue holds the input off.
// Reset (rst_n low, synchronous): control cleared, registers to 328/640/480, line
//   stores kept; in ready is low one refill cycle after reset and after a config write.
// ----------------------------------------------------------------------------
// depth_laplacian_edge_filter
// 4-neighbour Laplacian edge filter with threshold over a raster depth stream.
// ----------------------------------------------------------------------------
`include "depth_laplacian_edge_filter_defines.svh"

module depth_laplacian_edge_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  dlef_in_if.sink                           in_if,
  dlef_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [dlef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dlef_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Config registers
  logic [dlef_pkg::THR_W-1:0]  thr_r;
  logic [dlef_pkg::IMGW_W-1:0] width_r;
  logic [dlef_pkg::IMGH_W-1:0] height_r;

  // Effective geometry: width clamped to 1..MAX_WIDTH, height zero taken as one
  logic [dlef_pkg::WID_W-1:0]  w_eff;
  logic [dlef_pkg::ROW_W-1:0]  h_eff;

  // Front -> queue -> back
  logic                  f2q_push;
  logic                  b_pop;
  dlef_pkg::dlef_cmd_t   f2q_cmd;
  dlef_pkg::dlef_cmd_t   q_head;
  dlef_pkg::dlef_qstat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= dlef_pkg::THR_RESET;
      width_r  <= dlef_pkg::WIDTH_RESET;
      height_r <= dlef_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dlef_pkg::REG_EDGE_THRESHOLD: thr_r    <= cfg_wdata[dlef_pkg::THR_W-1:0];
        dlef_pkg::REG_IMAGE_WIDTH:    width_r  <= cfg_wdata[dlef_pkg::IMGW_W-1:0];
        dlef_pkg::REG_IMAGE_HEIGHT:   height_r <= cfg_wdata[dlef_pkg::IMGH_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_comb begin
    priority if (width_r == '0) begin
      w_eff = dlef_pkg::WID_W'(1);
    end else if (dlef_pkg::WID_W'(width_r) > dlef_pkg::WID_W'(dlef_pkg::MAX_WIDTH)) begin
      w_eff = dlef_pkg::WID_W'(dlef_pkg::MAX_WIDTH);
    end else begin
      w_eff = dlef_pkg::WID_W'(width_r);
    end
  end

  assign h_eff = (height_r == '0) ? dlef_pkg::ROW_W'(1) : height_r;

  // Front: raster position, line stores, drop of in-image flushes, job issue.
  // Any config write forces a prefetch refill at the repaired position.
  dlef_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .refresh_req (cfg_we),
    .w_eff       (w_eff),
    .h_eff       (h_eff),
    .in_ch       (in_if),
    .q_stat      (q_stat),
    .push        (f2q_push),
    .cmd         (f2q_cmd)
  );

  // Decoupling queue so a stalled output does not stop sample transfers at once
  dlef_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f2q_push),
    .push_cmd (f2q_cmd),
    .pop      (b_pop),
    .head     (q_head),
    .q_stat   (q_stat)
  );

  // Back: kernel sum, threshold compare, registered result
  dlef_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .thr    (thr_r),
    .head   (q_head),
    .q_stat (q_stat),
    .pop    (b_pop),
    .out_ch (out_if)
  );

  // Checks
  `DLEF_ASSERT_IMPL(a_q_no_overflow, clk, rst_n, f2q_push, !q_stat.full)
  `DLEF_ASSERT_IMPL(a_pop_needs_job, clk, rst_n, b_pop, !q_stat.empty)
  `DLEF_ASSERT_NEXT(a_cfg_holds_input, clk, rst_n, cfg_we, !in_if.ready)

endmodule
